@@ rtl/sls_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_pkg - shared types and constants of the status LED sequencer
// Command and level codes, register indexes, reset values, colour levels
// and the structs passed between the sequencer modules.
// ----------------------------------------------------------------------------
package sls_pkg;

	localparam int unsigned CMD_W   = 2;
	localparam int unsigned LVL_W   = 2;
	localparam int unsigned TICK_W  = 16;
	localparam int unsigned COLOR_W = 8;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned REG_DATA_W = 16;

	// item command codes
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_STATE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EVENT = 2'd2;

	// status levels
	localparam logic [LVL_W-1:0] LVL_NONE  = 2'd0;
	localparam logic [LVL_W-1:0] LVL_INFO  = 2'd1;
	localparam logic [LVL_W-1:0] LVL_WARN  = 2'd2;
	localparam logic [LVL_W-1:0] LVL_ERROR = 2'd3;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_SINGLE_PIN_MODE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_INVERT_PIN        = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_INFO_HALF_PERIOD  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WARN_HALF_PERIOD  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ERROR_HALF_PERIOD = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_INFO_PULSE_LEN    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_WARN_PULSE_LEN    = 3'd6;

	// register reset values
	localparam logic [TICK_W-1:0] INFO_HALF_PERIOD_RST  = 16'd1000;
	localparam logic [TICK_W-1:0] WARN_HALF_PERIOD_RST  = 16'd600;
	localparam logic [TICK_W-1:0] ERROR_HALF_PERIOD_RST = 16'd300;
	localparam logic [TICK_W-1:0] INFO_PULSE_LEN_RST    = 16'd35;
	localparam logic [TICK_W-1:0] WARN_PULSE_LEN_RST    = 16'd80;

	localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;
	localparam logic [COLOR_W-1:0] COLOR_OFF  = 8'd0;

	typedef struct packed {
		logic              single_pin_mode;
		logic              invert_pin;
		logic [TICK_W-1:0] info_half_period;
		logic [TICK_W-1:0] warn_half_period;
		logic [TICK_W-1:0] error_half_period;
		logic [TICK_W-1:0] info_pulse_len;
		logic [TICK_W-1:0] warn_pulse_len;
	} cfg_t;

	typedef struct packed {
		logic              blink_active;
		logic              lit_phase;
		logic [LVL_W-1:0]  shown_level;
		logic [TICK_W-1:0] phase_ticks;
		logic              pulse_active;
		logic [TICK_W-1:0] pulse_ticks_left;
		logic              error_latch;
		logic              error_blink_started;
	} led_state_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               pin_level;
		logic               blinking;
		logic               pulsing;
		logic               error_latched;
	} res_t;

endpackage

@@ rtl/sls_item_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_item_if - input item channel
// Valid/ready channel carrying one command and its level per beat.
// ----------------------------------------------------------------------------
interface sls_item_if;
	logic                        valid;
	logic                        ready;
	logic [sls_pkg::CMD_W-1:0]   cmd;
	logic [sls_pkg::LVL_W-1:0]   level;

	modport source (output valid, output cmd, output level, input ready);
	modport sink   (input valid, input cmd, input level, output ready);
endinterface

@@ rtl/sls_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_result_if - result channel
// Valid/ready channel carrying the LED view after each item.
// ----------------------------------------------------------------------------
interface sls_result_if;
	logic                          valid;
	logic                          ready;
	logic [sls_pkg::COLOR_W-1:0]   red;
	logic [sls_pkg::COLOR_W-1:0]   green;
	logic [sls_pkg::COLOR_W-1:0]   blue;
	logic                          pin_level;
	logic                          blinking;
	logic                          pulsing;
	logic                          error_latched;

	modport source (output valid, output red, output green, output blue,
		output pin_level, output blinking, output pulsing, output error_latched,
		input ready);
	modport sink   (input valid, input red, input green, input blue,
		input pin_level, input blinking, input pulsing, input error_latched,
		output ready);
endinterface

@@ rtl/sls_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_cfg_if - configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface sls_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [sls_pkg::REG_IDX_W-1:0]      index;
	logic [sls_pkg::REG_DATA_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/sls_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_cfg_regs - configuration register file
// Takes one register write per beat; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module sls_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	sls_cfg_if.sink        cfg,
	output sls_pkg::cfg_t  cfg_q
);

	logic wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.single_pin_mode   <= 1'b0;
			cfg_q.invert_pin        <= 1'b0;
			cfg_q.info_half_period  <= sls_pkg::INFO_HALF_PERIOD_RST;
			cfg_q.warn_half_period  <= sls_pkg::WARN_HALF_PERIOD_RST;
			cfg_q.error_half_period <= sls_pkg::ERROR_HALF_PERIOD_RST;
			cfg_q.info_pulse_len    <= sls_pkg::INFO_PULSE_LEN_RST;
			cfg_q.warn_pulse_len    <= sls_pkg::WARN_PULSE_LEN_RST;
		end else if (wr) begin
			case (cfg.index)
				sls_pkg::REG_SINGLE_PIN_MODE:   cfg_q.single_pin_mode   <= cfg.data[0];
				sls_pkg::REG_INVERT_PIN:        cfg_q.invert_pin        <= cfg.data[0];
				sls_pkg::REG_INFO_HALF_PERIOD:  cfg_q.info_half_period  <= cfg.data;
				sls_pkg::REG_WARN_HALF_PERIOD:  cfg_q.warn_half_period  <= cfg.data;
				sls_pkg::REG_ERROR_HALF_PERIOD: cfg_q.error_half_period <= cfg.data;
				sls_pkg::REG_INFO_PULSE_LEN:    cfg_q.info_pulse_len    <= cfg.data;
				sls_pkg::REG_WARN_PULSE_LEN:    cfg_q.warn_pulse_len    <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/sls_seq_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_seq_core - blink / pulse / error latch sequencer
// Updates the LED state once per accepted item and exposes the next state.
// ----------------------------------------------------------------------------
module sls_seq_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [sls_pkg::CMD_W-1:0]    cmd,
	input  logic [sls_pkg::LVL_W-1:0]    level,
	input  sls_pkg::cfg_t                cfg,
	output sls_pkg::led_state_t          st_q,
	output sls_pkg::led_state_t          st_next
);

	logic [sls_pkg::TICK_W-1:0] half_period;
	logic [sls_pkg::TICK_W-1:0] phase_inc;
	logic [sls_pkg::TICK_W-1:0] pulse_len;

	// Half period of the shown level, zero reads as one tick
	always_comb begin
		case (st_q.shown_level)
			sls_pkg::LVL_INFO: half_period = cfg.info_half_period;
			sls_pkg::LVL_WARN: half_period = cfg.warn_half_period;
			default:           half_period = cfg.error_half_period;
		endcase
		if (half_period == '0) begin
			half_period = sls_pkg::TICK_W'(1);
		end
	end

	assign phase_inc = st_q.phase_ticks + sls_pkg::TICK_W'(1);

	always_comb begin
		pulse_len = (level == sls_pkg::LVL_INFO) ? cfg.info_pulse_len : cfg.warn_pulse_len;
		if (pulse_len == '0) begin
			pulse_len = sls_pkg::TICK_W'(1);
		end
	end

	always_comb begin
		st_next = st_q;
		case (cmd)
			sls_pkg::CMD_TICK: begin
				if (st_q.blink_active) begin
					if (phase_inc >= half_period) begin
						st_next.lit_phase   = ~st_q.lit_phase;
						st_next.phase_ticks = '0;
					end else begin
						st_next.phase_ticks = phase_inc;
					end
				end else if (st_q.pulse_active) begin
					if (st_q.pulse_ticks_left <= sls_pkg::TICK_W'(1)) begin
						// pulse over: go dark, or start error blink once
						st_next.pulse_active     = 1'b0;
						st_next.pulse_ticks_left = '0;
						st_next.shown_level      = sls_pkg::LVL_NONE;
						st_next.phase_ticks      = '0;
						st_next.lit_phase        = 1'b0;
						if (st_q.error_latch && !st_q.error_blink_started) begin
							st_next.error_blink_started = 1'b1;
							st_next.blink_active        = 1'b1;
							st_next.lit_phase           = 1'b1;
							st_next.shown_level         = sls_pkg::LVL_ERROR;
						end
					end else begin
						st_next.pulse_ticks_left = st_q.pulse_ticks_left - sls_pkg::TICK_W'(1);
					end
				end
			end
			sls_pkg::CMD_STATE: begin
				if (!st_q.error_latch || level == sls_pkg::LVL_ERROR) begin
					st_next.blink_active     = (level != sls_pkg::LVL_NONE);
					st_next.lit_phase        = (level != sls_pkg::LVL_NONE);
					st_next.shown_level      = level;
					st_next.phase_ticks      = '0;
					st_next.pulse_active     = 1'b0;
					st_next.pulse_ticks_left = '0;
				end
			end
			sls_pkg::CMD_EVENT: begin
				if (level != sls_pkg::LVL_NONE && !st_q.error_latch) begin
					if (level == sls_pkg::LVL_ERROR) begin
						st_next.error_latch = 1'b1;
						// during a pulse the blink waits for its end
						if (!st_q.pulse_active && !st_q.error_blink_started) begin
							st_next.error_blink_started = 1'b1;
							st_next.blink_active        = 1'b1;
							st_next.lit_phase           = 1'b1;
							st_next.shown_level         = sls_pkg::LVL_ERROR;
							st_next.phase_ticks         = '0;
							st_next.pulse_active        = 1'b0;
							st_next.pulse_ticks_left    = '0;
						end
					end else begin
						st_next.blink_active     = 1'b0;
						st_next.lit_phase        = 1'b0;
						st_next.phase_ticks      = '0;
						st_next.pulse_active     = 1'b1;
						st_next.pulse_ticks_left = pulse_len;
						st_next.shown_level      = level;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (accept) begin
			st_q <= st_next;
		end
	end

endmodule

@@ rtl/sls_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_out_stage - result formatting and output buffer
// Maps LED state to colours or pin level; output register plus skid entry.
// ----------------------------------------------------------------------------
module sls_out_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  sls_pkg::led_state_t   st,
	input  sls_pkg::cfg_t         cfg,
	output logic                  space,
	sls_result_if.source          result
);

	logic          lit;
	logic          red_on;
	logic          green_on;
	sls_pkg::res_t res_new;
	sls_pkg::res_t out_data_q;
	sls_pkg::res_t skid_data_q;
	logic          out_valid_q;
	logic          skid_valid_q;
	logic          out_free;

	always_comb begin
		lit      = st.pulse_active || (st.blink_active && st.lit_phase);
		red_on   = lit && (st.shown_level inside {sls_pkg::LVL_WARN, sls_pkg::LVL_ERROR});
		green_on = lit && (st.shown_level inside {sls_pkg::LVL_INFO, sls_pkg::LVL_WARN});

		res_new.red           = (red_on && !cfg.single_pin_mode) ? sls_pkg::COLOR_FULL
			: sls_pkg::COLOR_OFF;
		res_new.green         = (green_on && !cfg.single_pin_mode) ? sls_pkg::COLOR_FULL
			: sls_pkg::COLOR_OFF;
		res_new.blue          = sls_pkg::COLOR_OFF;
		res_new.pin_level     = cfg.single_pin_mode && ((red_on || green_on) ^ cfg.invert_pin);
		res_new.blinking      = st.blink_active;
		res_new.pulsing       = st.pulse_active;
		res_new.error_latched = st.error_latch;
	end

	assign space    = ~skid_valid_q;
	assign out_free = ~out_valid_q | result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q | push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : res_new;
		end else if (push) begin
			skid_data_q <= res_new;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.red           = out_data_q.red;
	assign result.green         = out_data_q.green;
	assign result.blue          = out_data_q.blue;
	assign result.pin_level     = out_data_q.pin_level;
	assign result.blinking      = out_data_q.blinking;
	assign result.pulsing       = out_data_q.pulsing;
	assign result.error_latched = out_data_q.error_latched;

endmodule

@@ rtl/status_led_sequencer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_led_sequencer_unit - status LED sequencer top level
// Runs blink patterns, one-shot log pulses and the error latch from a
// stream of tick, state and log event items; one result beat per item.
// ----------------------------------------------------------------------------
//
//  channel   dir   beat contents                     handshake
//  -------   ---   -------------------------------   -----------
//  item      in    cmd, level                        valid/ready
//  result    out   red, green, blue, pin_level,      valid/ready
//                  blinking, pulsing, error_latched
//  cfg       in    index, data (register write)      valid/ready
//
// One item per clock while the skid entry is free: the state update and the colour
// mapping are combinational between the state registers and the output register.
// The result is registered in the output register, or in the skid entry on a stall.
// A skid entry behind the output register keeps item.ready registered; it
// drops only after two results pile up behind a stalled result channel.
// Reset clears the LED state and loads the register defaults; cfg is always
// ready.
// ----------------------------------------------------------------------------
module status_led_sequencer_unit (
	input  logic           clk,
	input  logic           arst_n,
	sls_item_if.sink       item,
	sls_result_if.source   result,
	sls_cfg_if.sink        cfg
);

	sls_pkg::cfg_t       cfg_q;
	sls_pkg::led_state_t st_q;
	sls_pkg::led_state_t st_next;
	logic                space;
	logic                accept;

	// Hold the register set
	sls_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	// Take an item whenever the output side has room
	assign item.ready = space;
	assign accept     = item.valid & space;

	// Advance blink, pulse and error latch state per item
	sls_seq_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.cmd     (item.cmd),
		.level   (item.level),
		.cfg     (cfg_q),
		.st_q    (st_q),
		.st_next (st_next)
	);

	// Map the new state to colours and buffer the result beat
	sls_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.st     (st_next),
		.cfg    (cfg_q),
		.space  (space),
		.result (result)
	);

	// Once set, the error latch stays set
	a_latch_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.error_latch |=> st_q.error_latch)
		else $error("error latch cleared");

	// Blink and pulse never run together
	a_blink_pulse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_q.blink_active && st_q.pulse_active))
		else $error("blink and pulse both active");

	// Error blink only starts from a set latch
	a_started_needs_latch: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.error_blink_started |-> st_q.error_latch)
		else $error("error blink started without latch");

	// Every accepted item leaves a result waiting next cycle
	a_item_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> result.valid)
		else $error("accepted item produced no result");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the status LED sequencer
// Streams tick, state and log event beats into the block with random gaps
// and result stalls. A shadow copy of the LED state predicts the LED view
// after every accepted item, and each result beat is checked field by field
// in order. The run walks through several register settings, including the
// defaults, zero lengths and the widest periods, and ends with the error
// latch set.
// ----------------------------------------------------------------------------
module tb_top;

	// command code with no function; the block must leave its state alone
	localparam logic [sls_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	// cycles without any handshake before the run is declared hung
	localparam int QUIET_LIMIT = 2000;

	// ------------------------------------------------------------------------
	// Shadow of the LED state: predicts the view after each item and holds
	// the views still due on the result channel.
	// ------------------------------------------------------------------------
	class led_view_board;
		sls_pkg::cfg_t       regs;
		sls_pkg::led_state_t st;
		sls_pkg::res_t       views_due[$];
		int                  fails;

		function new();
			regs.single_pin_mode   = 1'b0;
			regs.invert_pin        = 1'b0;
			regs.info_half_period  = sls_pkg::INFO_HALF_PERIOD_RST;
			regs.warn_half_period  = sls_pkg::WARN_HALF_PERIOD_RST;
			regs.error_half_period = sls_pkg::ERROR_HALF_PERIOD_RST;
			regs.info_pulse_len    = sls_pkg::INFO_PULSE_LEN_RST;
			regs.warn_pulse_len    = sls_pkg::WARN_PULSE_LEN_RST;
			st    = '0;
			fails = 0;
		endfunction

		task report(string what);
			$display("MISMATCH @%0t: %s", $realtime, what);
			fails++;
		endtask

		function int pending();
			return views_due.size();
		endfunction

		function void note_reg(logic [sls_pkg::REG_IDX_W-1:0] idx,
				logic [sls_pkg::REG_DATA_W-1:0] data);
			case (idx)
				sls_pkg::REG_SINGLE_PIN_MODE:   regs.single_pin_mode   = data[0];
				sls_pkg::REG_INVERT_PIN:        regs.invert_pin        = data[0];
				sls_pkg::REG_INFO_HALF_PERIOD:  regs.info_half_period  = data;
				sls_pkg::REG_WARN_HALF_PERIOD:  regs.warn_half_period  = data;
				sls_pkg::REG_ERROR_HALF_PERIOD: regs.error_half_period = data;
				sls_pkg::REG_INFO_PULSE_LEN:    regs.info_pulse_len    = data;
				sls_pkg::REG_WARN_PULSE_LEN:    regs.warn_pulse_len    = data;
				default: ;
			endcase
		endfunction

		// half period of the shown colour, read live; zero counts as one
		function logic [sls_pkg::TICK_W-1:0] half_of(logic [sls_pkg::LVL_W-1:0] lvl);
			logic [sls_pkg::TICK_W-1:0] hp;
			case (lvl)
				sls_pkg::LVL_INFO: hp = regs.info_half_period;
				sls_pkg::LVL_WARN: hp = regs.warn_half_period;
				default:           hp = regs.error_half_period;
			endcase
			return (hp == '0) ? sls_pkg::TICK_W'(1) : hp;
		endfunction

		function void go_dark();
			st.blink_active     = 1'b0;
			st.lit_phase        = 1'b0;
			st.phase_ticks      = '0;
			st.pulse_active     = 1'b0;
			st.pulse_ticks_left = '0;
			st.shown_level      = sls_pkg::LVL_NONE;
		endfunction

		function void begin_blink(logic [sls_pkg::LVL_W-1:0] lvl);
			go_dark();
			st.blink_active = 1'b1;
			st.lit_phase    = 1'b1;
			st.shown_level  = lvl;
		endfunction

		// the latch kicks off red blinking only the first time
		function void latch_blink_once();
			if (st.error_blink_started)
				return;
			st.error_blink_started = 1'b1;
			begin_blink(sls_pkg::LVL_ERROR);
		endfunction

		function void on_tick();
			if (st.blink_active) begin
				st.phase_ticks = st.phase_ticks + 1'b1;
				if (st.phase_ticks >= half_of(st.shown_level)) begin
					st.lit_phase   = !st.lit_phase;
					st.phase_ticks = '0;
				end
			end else if (st.pulse_active) begin
				if (st.pulse_ticks_left <= 1) begin
					go_dark();
					if (st.error_latch)
						latch_blink_once();
				end else begin
					st.pulse_ticks_left = st.pulse_ticks_left - 1'b1;
				end
			end
		endfunction

		function void on_state(logic [sls_pkg::LVL_W-1:0] lvl);
			if (st.error_latch && lvl != sls_pkg::LVL_ERROR)
				return;
			if (lvl == sls_pkg::LVL_NONE)
				go_dark();
			else
				begin_blink(lvl);
		endfunction

		function void on_event(logic [sls_pkg::LVL_W-1:0] lvl);
			logic [sls_pkg::TICK_W-1:0] len;
			if (lvl == sls_pkg::LVL_NONE || st.error_latch)
				return;
			if (lvl == sls_pkg::LVL_ERROR) begin
				st.error_latch = 1'b1;
				if (!st.pulse_active)
					latch_blink_once();
				return;
			end
			go_dark();
			len = (lvl == sls_pkg::LVL_INFO) ? regs.info_pulse_len : regs.warn_pulse_len;
			st.pulse_active     = 1'b1;
			st.pulse_ticks_left = (len == '0) ? sls_pkg::TICK_W'(1) : len;
			st.shown_level      = lvl;
		endfunction

		// advance the shadow by one item and queue the LED view it leaves
		function void note_item(logic [sls_pkg::CMD_W-1:0] cmd,
				logic [sls_pkg::LVL_W-1:0] lvl);
			sls_pkg::res_t               view;
			logic [sls_pkg::COLOR_W-1:0] r, g;
			logic                        lit;
			case (cmd)
				sls_pkg::CMD_TICK:  on_tick();
				sls_pkg::CMD_STATE: on_state(lvl);
				sls_pkg::CMD_EVENT: on_event(lvl);
				default: ;
			endcase
			r   = sls_pkg::COLOR_OFF;
			g   = sls_pkg::COLOR_OFF;
			lit = st.pulse_active || (st.blink_active && st.lit_phase);
			if (lit) begin
				case (st.shown_level)
					sls_pkg::LVL_INFO: g = sls_pkg::COLOR_FULL;
					sls_pkg::LVL_WARN: begin
						r = sls_pkg::COLOR_FULL;
						g = sls_pkg::COLOR_FULL;
					end
					sls_pkg::LVL_ERROR: r = sls_pkg::COLOR_FULL;
					default: ;
				endcase
			end
			lit  = (r | g) != '0;
			view = '0;
			if (regs.single_pin_mode) begin
				view.pin_level = lit ^ regs.invert_pin;
			end else begin
				view.red   = r;
				view.green = g;
			end
			view.blinking      = st.blink_active;
			view.pulsing       = st.pulse_active;
			view.error_latched = st.error_latch;
			views_due.push_back(view);
		endfunction

		task cmp(string name, logic [sls_pkg::COLOR_W-1:0] got,
				logic [sls_pkg::COLOR_W-1:0] want);
			if (got !== want)
				report($sformatf("%s got %0d, want %0d", name, got, want));
		endtask

		task check_view(sls_pkg::res_t got);
			sls_pkg::res_t want;
			if (views_due.size() == 0) begin
				report("result beat with no item waiting for it");
				return;
			end
			want = views_due.pop_front();
			cmp("red",   got.red,   want.red);
			cmp("green", got.green, want.green);
			cmp("blue",  got.blue,  want.blue);
			cmp("pin_level", sls_pkg::COLOR_W'(got.pin_level),
				sls_pkg::COLOR_W'(want.pin_level));
			cmp("blinking", sls_pkg::COLOR_W'(got.blinking),
				sls_pkg::COLOR_W'(want.blinking));
			cmp("pulsing", sls_pkg::COLOR_W'(got.pulsing),
				sls_pkg::COLOR_W'(want.pulsing));
			cmp("error_latched", sls_pkg::COLOR_W'(got.error_latched),
				sls_pkg::COLOR_W'(want.error_latched));
		endtask
	endclass

	logic clk;
	logic arst_n;

	sls_item_if   item_ch ();
	sls_result_if res_ch ();
	sls_cfg_if    cfg_ch ();

	status_led_sequencer_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	led_view_board board = new();

	// calm: a stretch where neither side idles
	bit calm;
	int stall_left;
	int quiet;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Result side: check every beat at the rising edge, then draw the stall
	// for the next one. Ready moves only on the falling edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		sls_pkg::res_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.red           = res_ch.red;
			got.green         = res_ch.green;
			got.blue          = res_ch.blue;
			got.pin_level     = res_ch.pin_level;
			got.blinking      = res_ch.blinking;
			got.pulsing       = res_ch.pulsing;
			got.error_latched = res_ch.error_latched;
			board.check_view(got);
			stall_left = calm ? 0 : $urandom_range(0, 3);
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			res_ch.ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Watchdog: any beat on any channel clears the count.
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet = 0;
		else
			quiet = quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Timeout: no beat for %0d cycles", QUIET_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Drive tasks. Each starts and ends on a falling edge.
	// ------------------------------------------------------------------------

	// Send one item after a random gap; hold it until the block takes it.
	task send_item(logic [sls_pkg::CMD_W-1:0] cmd, logic [sls_pkg::LVL_W-1:0] lvl);
		int gap;
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.cmd   <= cmd;
		item_ch.level <= lvl;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		board.note_item(cmd, lvl);
		@(negedge clk);
	endtask

	// Drop the item valid and wait until every queued view has come back.
	task drain();
		item_ch.valid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
	endtask

	// Write all seven registers back to back; only call with the block idle.
	task load_settings(logic mode, logic inv, logic [15:0] ihp, logic [15:0] whp,
			logic [15:0] ehp, logic [15:0] ipl, logic [15:0] wpl);
		logic [sls_pkg::REG_DATA_W-1:0] vals [7];
		vals = '{sls_pkg::REG_DATA_W'(mode), sls_pkg::REG_DATA_W'(inv),
			ihp, whp, ehp, ipl, wpl};
		for (int i = 0; i < 7; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= sls_pkg::REG_IDX_W'(i);
			cfg_ch.data  <= vals[i];
			@(posedge clk);
			while (!cfg_ch.ready)
				@(posedge clk);
			board.note_reg(sls_pkg::REG_IDX_W'(i), vals[i]);
			@(negedge clk);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Random traffic: runs of ticks so blinks toggle and pulses run out,
	// mixed with state commands, log events and the odd unused code.
	// Error log events only where the latch is allowed to close.
	task run_mix(int count, bit allow_latch);
		int done;
		int pick;
		int burst;
		done = 0;
		while (done < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 42) begin
				burst = $urandom_range(1, 12);
				repeat (burst)
					send_item(sls_pkg::CMD_TICK, sls_pkg::LVL_W'($urandom_range(0, 3)));
				done += burst;
			end else if (pick < 64) begin
				send_item(sls_pkg::CMD_STATE, sls_pkg::LVL_W'($urandom_range(0, 3)));
				done++;
			end else if (pick < 95) begin
				send_item(sls_pkg::CMD_EVENT,
					sls_pkg::LVL_W'($urandom_range(0, allow_latch ? 3 : 2)));
				done++;
			end else begin
				send_item(CMD_UNUSED, sls_pkg::LVL_W'($urandom_range(0, 3)));
				done++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		calm          = 1'b0;
		stall_left    = 0;
		quiet         = 0;
		item_ch.valid = 1'b0;
		item_ch.cmd   = sls_pkg::CMD_TICK;
		item_ch.level = sls_pkg::LVL_NONE;
		res_ch.ready  = 1'b0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = '0;
		cfg_ch.data   = '0;

		// hold reset, then release it on a falling edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, reset defaults: every state level, the unused code,
		// an ignored empty event and a pulse replacing a pulse.
		send_item(sls_pkg::CMD_STATE, sls_pkg::LVL_INFO);
		send_item(sls_pkg::CMD_TICK, sls_pkg::LVL_NONE);
		send_item(sls_pkg::CMD_STATE, sls_pkg::LVL_WARN);
		send_item(sls_pkg::CMD_STATE, sls_pkg::LVL_ERROR);
		send_item(sls_pkg::CMD_STATE, sls_pkg::LVL_NONE);
		send_item(CMD_UNUSED, sls_pkg::LVL_ERROR);
		send_item(sls_pkg::CMD_EVENT, sls_pkg::LVL_NONE);
		send_item(sls_pkg::CMD_EVENT, sls_pkg::LVL_INFO);
		send_item(sls_pkg::CMD_EVENT, sls_pkg::LVL_WARN);
		send_item(sls_pkg::CMD_STATE, sls_pkg::LVL_INFO);
		// random on the defaults
		run_mix(120, 1'b0);
		drain();

		// Zero half period and zero pulse length act as one tick.
		load_settings(1'b0, 1'b1, 16'd0, 16'd3, 16'd2, 16'd0, 16'd4);
		send_item(sls_pkg::CMD_STATE, sls_pkg::LVL_INFO);
		send_item(sls_pkg::CMD_TICK, sls_pkg::LVL_INFO);
		send_item(sls_pkg::CMD_TICK, sls_pkg::LVL_WARN);
		send_item(sls_pkg::CMD_EVENT, sls_pkg::LVL_WARN);
		send_item(sls_pkg::CMD_TICK, sls_pkg::LVL_NONE);
		send_item(sls_pkg::CMD_STATE, sls_pkg::LVL_WARN);
		send_item(sls_pkg::CMD_EVENT, sls_pkg::LVL_INFO);
		send_item(sls_pkg::CMD_TICK, sls_pkg::LVL_NONE);
		run_mix(150, 1'b0);
		drain();

		// single pin, plain then inverted, with short random timings
		load_settings(1'b1, 1'b0, 16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
			16'($urandom_range(1, 6)), 16'($urandom_range(1, 8)),
			16'($urandom_range(1, 8)));
		run_mix(150, 1'b0);
		drain();
		load_settings(1'b1, 1'b1, 16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
			16'($urandom_range(1, 6)), 16'($urandom_range(1, 8)),
			16'($urandom_range(1, 8)));
		run_mix(150, 1'b0);
		drain();

		// widest periods and info pulse, shortest warning pulse
		load_settings(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
		run_mix(80, 1'b0);
		drain();

		// Shrink the periods and send a tick, then latch the error during a pulse:
		// red starts only when the pulse runs out, and afterwards only an error
		// state command is obeyed.
		load_settings(1'b0, 1'b0, 16'd2, 16'd1, 16'd2, 16'd3, 16'd2);
		send_item(sls_pkg::CMD_TICK, sls_pkg::LVL_NONE);
		send_item(sls_pkg::CMD_EVENT, sls_pkg::LVL_INFO);
		send_item(sls_pkg::CMD_EVENT, sls_pkg::LVL_ERROR);
		repeat (3) send_item(sls_pkg::CMD_TICK, sls_pkg::LVL_NONE);
		send_item(sls_pkg::CMD_TICK, sls_pkg::LVL_NONE);
		send_item(sls_pkg::CMD_TICK, sls_pkg::LVL_NONE);
		send_item(sls_pkg::CMD_STATE, sls_pkg::LVL_INFO);
		send_item(sls_pkg::CMD_EVENT, sls_pkg::LVL_WARN);
		send_item(sls_pkg::CMD_EVENT, sls_pkg::LVL_ERROR);
		send_item(sls_pkg::CMD_STATE, sls_pkg::LVL_NONE);
		send_item(sls_pkg::CMD_STATE, sls_pkg::LVL_ERROR);
		run_mix(150, 1'b1);
		drain();

		// still latched: new output mode and error period
		load_settings(1'b1, 1'b1, 16'($urandom_range(1, 5)), 16'($urandom_range(1, 5)),
			16'($urandom_range(1, 5)), 16'($urandom_range(1, 5)),
			16'($urandom_range(1, 5)));
		run_mix(100, 1'b1);
		drain();

		// let any stray beat show up before the verdict
		repeat (8) @(posedge clk);
		if (board.fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/sls_pkg.sv
rtl/sls_item_if.sv
rtl/sls_result_if.sv
rtl/sls_cfg_if.sv
rtl/sls_cfg_regs.sv
rtl/sls_seq_core.sv
rtl/sls_out_stage.sv
rtl/status_led_sequencer_unit.sv
test/tb_top.sv
